// ===== rtl/hsah_pkg.sv =====
// ============================================================================
// hsah_pkg
// Shared widths and constants of the hourly sensor average history block.
// ============================================================================
package hsah_pkg;

    // Beat field widths
    localparam int TEMP_W     = 15;
    localparam int HUM_RAW_W  = 17;
    localparam int HUM_AVG_W  = 7;
    localparam int SLOT_OUT_W = 5;
    localparam int COUNT_W    = 8;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_READINGS_PER_WINDOW = 1'b0;   // word index of the one register
    localparam logic [COUNT_W-1:0] READINGS_PER_WINDOW_RESET = 8'd60;

    // Arithmetic
    localparam int DIV_W   = 24;                       // divider dividend width
    localparam int DEN_W   = 10;                       // divider divisor width
    localparam int CNT_W   = 4;                        // divider step counter width
    localparam logic [DEN_W-1:0]     HUM_DIVISOR = 10'd1000;
    localparam logic [HUM_AVG_W-1:0] HUM_MAX     = 7'd127;

    // Humidity scaling: multiply by ceil(2^27 / 1000) and keep the bits above
    // bit 27, exact for every 17-bit raw reading
    localparam int HUM_RECIP_W     = 18;
    localparam int HUM_RECIP_SHIFT = 27;
    localparam logic [HUM_RECIP_W-1:0] HUM_RECIP = 18'd134218;

    // Divider steps, two quotient bits per step
    localparam logic [CNT_W-1:0] STEPS_TEMP      = 4'd12;   // 24-bit dividend
    localparam logic [CNT_W-1:0] STEPS_HUM_AVG   = 4'd8;    // 16-bit dividend

endpackage

// ===== rtl/hsah_if.sv =====
// ============================================================================
// hsah_in_if / hsah_out_if
// Valid/ready channels for sensor readings and running-average results.
// ============================================================================
interface hsah_in_if import hsah_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [TEMP_W-1:0]    temp_sample;
    logic        [HUM_RAW_W-1:0] humidity_sample;

    modport source (output valid, temp_sample, humidity_sample, input ready);
    modport sink   (input valid, temp_sample, humidity_sample, output ready);
endinterface

interface hsah_out_if import hsah_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [TEMP_W-1:0]     temp_average;
    logic        [HUM_AVG_W-1:0]  humidity_average;
    logic        [SLOT_OUT_W-1:0] slot_index;
    logic        [COUNT_W-1:0]    readings_in_window;
    logic                         window_rolled;

    modport source (output valid, temp_average, humidity_average, slot_index,
                    readings_in_window, window_rolled, input ready);
    modport sink   (input valid, temp_average, humidity_average, slot_index,
                    readings_in_window, window_rolled, output ready);
endinterface

// ===== rtl/hourly_sensor_average_history.sv =====
// ============================================================================
// hourly_sensor_average_history
// Running per-slot mean of temperature and scaled humidity, one slot per
// window of readings, built around one shared multiplier and one divider.
// ============================================================================
//
//  channel   dir  type         fields
//  --------  ---  -----------  -------------------------------------------------
//  in_ch     in   hsah_in_if   temp_sample, humidity_sample
//  out_ch    out  hsah_out_if  temp_average, humidity_average, slot_index,
//                              readings_in_window, window_rolled
//  apb       in   APB          readings_per_window at byte address 0
//
//  A reading runs from the idle state that takes the beat through the
//  shared divider, which retires two quotient bits a cycle: 12 steps for the
//  temperature mean, 8 for the humidity mean, each after a multiply and an add
//  state, then the hand-off; no new beat is taken until the reading is through.
//  Humidity is divided by 1000 through a reciprocal multiply as the beat is taken.
//  Reset clears the window count, the slot index and both running means.
//  A result waits in the output register while the next reading is taken;
//  the hand-off cycle holds when the previous result has not yet gone out.
//
//  Only the current slot is ever read back: a new slot starts from zero and
//  older slots never reach the ports, so the shift of the history on
//  overflow reduces to holding the slot index at SLOTS-1.
//
module hourly_sensor_average_history
    import hsah_pkg::*;
#(
    parameter int SLOTS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    // APB-style configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // Beat channels
    hsah_in_if.sink            in_ch,
    hsah_out_if.source         out_ch
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    typedef enum logic [3:0] {
        IDLE,       // wait for a reading, scale humidity
        T_MUL,      // temperature mean times (n-1)
        T_ADD,      // add sample, load divider with magnitude
        T_DIV,      // divide by n, restore sign
        H_MUL,      // humidity mean times (n-1)
        H_ADD,      // add scaled sample, load divider
        H_DIV,      // divide by n
        FINISH      // hand the result to the output register
    } state_t;

    state_t state_reg;

    // Configuration
    logic [COUNT_W-1:0] rpw_reg;

    // Window state: the current slot and its running means
    logic [COUNT_W-1:0]          wcount_reg;
    logic [SLOT_W-1:0]           slot_reg;
    logic signed [TEMP_W-1:0]    tavg_reg;
    logic [HUM_AVG_W-1:0]        havg_reg;
    logic                        rolled_reg;

    // Per-reading working registers
    logic signed [TEMP_W-1:0]    temp_s_reg;
    logic [HUM_AVG_W-1:0]        hum_reg;
    logic signed [DIV_W-1:0]     prod_reg;
    logic                        neg_reg;

    // Shared divider
    logic [DIV_W-1:0]  div_quo_reg;
    logic [DEN_W-1:0]  div_rem_reg;
    logic [DEN_W-1:0]  div_den_reg;
    logic [CNT_W-1:0]  div_cnt_reg;
    logic [DIV_W-1:0]  div_quo_next;
    logic [DEN_W-1:0]  div_rem_next;
    logic [DEN_W:0]    step_hi;
    logic [DEN_W:0]    step_lo;
    logic              div_last;

    // Output register
    logic                         out_valid_reg;
    logic signed [TEMP_W-1:0]     out_temp_reg;
    logic [HUM_AVG_W-1:0]         out_hum_reg;
    logic [SLOT_OUT_W-1:0]        out_slot_reg;
    logic [COUNT_W-1:0]           out_count_reg;
    logic                         out_rolled_reg;

    // Datapath helpers
    logic signed [TEMP_W-1:0]     mul_a;
    logic signed [COUNT_W:0]      mul_b;
    logic signed [DIV_W-1:0]      mul_p;
    logic signed [DIV_W-1:0]      t_num;
    logic [DIV_W-1:0]             t_mag;
    logic [DIV_W-HUM_AVG_W-1:0]   h_num;
    logic [HUM_RAW_W+HUM_RECIP_W-1:0]                 hum_prod;
    logic [HUM_RAW_W+HUM_RECIP_W-HUM_RECIP_SHIFT-1:0] hum_quo;
    logic [SLOT_W+SLOT_OUT_W-1:0] slot_ext;
    logic                         in_fire;
    logic                         out_free;
    logic                         cfg_write;
    logic                         rolls;

    // One restoring division step: shift in a dividend bit, subtract if it fits.
    function automatic logic [DEN_W:0] div_step(input logic [DEN_W-1:0] rem,
                                                input logic             din,
                                                input logic [DEN_W-1:0] den);
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        trial = {rem, din};
        diff  = trial - {1'b0, den};
        if (trial >= {1'b0, den})
            div_step = {diff[DEN_W-1:0], 1'b1};
        else
            div_step = {trial[DEN_W-1:0], 1'b0};
    endfunction

    // Two quotient bits per cycle
    always_comb
    begin
        step_hi      = div_step(div_rem_reg, div_quo_reg[DIV_W-1], div_den_reg);
        step_lo      = div_step(step_hi[DEN_W:1], div_quo_reg[DIV_W-2], div_den_reg);
        div_rem_next = step_lo[DEN_W:1];
        div_quo_next = {div_quo_reg[DIV_W-3:0], step_hi[0], step_lo[0]};
    end

    assign div_last = (div_cnt_reg == CNT_W'(1));

    // Raw humidity / 1000 by reciprocal multiplication
    assign hum_prod = in_ch.humidity_sample * HUM_RECIP;
    assign hum_quo  = hum_prod[HUM_RAW_W+HUM_RECIP_W-1:HUM_RECIP_SHIFT];

    // Shared multiplier: the mean of the current slot times (n-1)
    assign mul_a = (state_reg == T_MUL) ? tavg_reg
                                        : $signed({{(TEMP_W-HUM_AVG_W){1'b0}}, havg_reg});
    assign mul_b = $signed({1'b0, wcount_reg - COUNT_W'(1)});
    assign mul_p = mul_a * mul_b;

    assign t_num = prod_reg + {{(DIV_W-TEMP_W){temp_s_reg[TEMP_W-1]}}, temp_s_reg};
    assign t_mag = t_num[DIV_W-1] ? DIV_W'(-t_num) : DIV_W'(t_num);
    assign h_num = {1'b0, prod_reg[DIV_W-HUM_AVG_W-2:0]}
                 + {{(DIV_W-2*HUM_AVG_W){1'b0}}, hum_reg};

    // A full window (or a zero window length) opens the next slot
    assign rolls    = (wcount_reg >= rpw_reg);
    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;
    assign slot_ext = {{SLOT_OUT_W{1'b0}}, slot_reg};

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_READINGS_PER_WINDOW)
                     ? {{(PDATA_W-COUNT_W){1'b0}}, rpw_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpw_reg <= READINGS_PER_WINDOW_RESET;
        end
        else if (cfg_write && paddr[2] == REG_READINGS_PER_WINDOW)
        begin
            rpw_reg <= pwdata[COUNT_W-1:0];
        end
    end

    // Sequencer, datapath and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            wcount_reg    <= '0;
            slot_reg      <= '0;
            tavg_reg      <= '0;
            havg_reg      <= '0;
            rolled_reg    <= 1'b0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Drop the result once the sink has taken it; the hand-off
            // cycle loads the register itself
            if (out_valid_reg && out_ch.ready && state_reg != FINISH)
                out_valid_reg <= 1'b0;

            case (state_reg)
                IDLE:
                begin
                    if (in_fire)
                    begin
                        temp_s_reg <= in_ch.temp_sample;
                        rolled_reg <= rolls;
                        if (rolls)
                        begin
                            // Advance the slot; at the last slot the history shifts
                            // and the last slot is reused
                            if (slot_reg < LAST_SLOT)
                                slot_reg <= slot_reg + SLOT_W'(1);
                            wcount_reg <= COUNT_W'(1);
                            tavg_reg   <= '0;
                            havg_reg   <= '0;
                        end
                        else
                        begin
                            wcount_reg <= wcount_reg + COUNT_W'(1);
                        end
                        // Saturate the scaled humidity
                        if (hum_quo > {1'b0, HUM_MAX})
                            hum_reg <= HUM_MAX;
                        else
                            hum_reg <= hum_quo[HUM_AVG_W-1:0];
                        state_reg <= T_MUL;
                    end
                end

                T_MUL:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= T_ADD;
                end

                T_ADD:
                begin
                    // Divide the magnitude so the quotient truncates toward zero
                    neg_reg     <= t_num[DIV_W-1];
                    div_quo_reg <= t_mag;
                    div_rem_reg <= '0;
                    div_den_reg <= {{(DEN_W-COUNT_W){1'b0}}, wcount_reg};
                    div_cnt_reg <= STEPS_TEMP;
                    state_reg   <= T_DIV;
                end

                T_DIV:
                begin
                    div_quo_reg <= div_quo_next;
                    div_rem_reg <= div_rem_next;
                    div_cnt_reg <= div_cnt_reg - CNT_W'(1);
                    if (div_last)
                    begin
                        if (neg_reg)
                            tavg_reg <= $signed(-div_quo_next[TEMP_W-1:0]);
                        else
                            tavg_reg <= $signed(div_quo_next[TEMP_W-1:0]);
                        state_reg <= H_MUL;
                    end
                end

                H_MUL:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= H_ADD;
                end

                H_ADD:
                begin
                    // 16-bit dividend aligned to the top
                    div_quo_reg <= {h_num[2*STEPS_HUM_AVG-1:0],
                                    {(DIV_W-2*STEPS_HUM_AVG){1'b0}}};
                    div_rem_reg <= '0;
                    div_den_reg <= {{(DEN_W-COUNT_W){1'b0}}, wcount_reg};
                    div_cnt_reg <= STEPS_HUM_AVG;
                    state_reg   <= H_DIV;
                end

                H_DIV:
                begin
                    div_quo_reg <= div_quo_next;
                    div_rem_reg <= div_rem_next;
                    div_cnt_reg <= div_cnt_reg - CNT_W'(1);
                    if (div_last)
                    begin
                        havg_reg  <= div_quo_next[HUM_AVG_W-1:0];
                        state_reg <= FINISH;
                    end
                end

                FINISH:
                begin
                    // Hold until the output register is free
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_temp_reg   <= tavg_reg;
                        out_hum_reg    <= havg_reg;
                        out_slot_reg   <= slot_ext[SLOT_OUT_W-1:0];
                        out_count_reg  <= wcount_reg;
                        out_rolled_reg <= rolled_reg;
                        state_reg      <= IDLE;
                    end
                end

                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign in_ch.ready               = (state_reg == IDLE);
    assign out_ch.valid              = out_valid_reg;
    assign out_ch.temp_average       = out_temp_reg;
    assign out_ch.humidity_average   = out_hum_reg;
    assign out_ch.slot_index         = out_slot_reg;
    assign out_ch.readings_in_window = out_count_reg;
    assign out_ch.window_rolled      = out_rolled_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // A reading keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ch.ready)
        else $error("input accepted again right after a beat");

    // The slot index never passes the last slot
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= LAST_SLOT)
        else $error("slot index beyond the last slot");

    // A result always counts at least one reading in its slot
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.readings_in_window != '0)
        else $error("result with an empty window");

    // A reading that opens a new slot is the first reading of it
    a_roll_first: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.window_rolled) |-> out_ch.readings_in_window == COUNT_W'(1))
        else $error("rolled result is not the first of its slot");

endmodule
